// ===== src/pcc_pkg.sv =====
// Package: shared types, constants and state codes for the clamped PID controller.
package pcc_pkg;

  localparam int unsigned DEV_W  = 16;
  localparam int unsigned TS_W   = 16;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned LIM_W  = 32;
  localparam int unsigned INT_W  = 48;
  localparam int unsigned MUL_AW = 17;
  localparam int unsigned MUL_BW = 33;
  localparam int unsigned ACC_W  = MUL_AW + MUL_BW;
  localparam int unsigned QUO_W  = 32;
  localparam int unsigned CFG_IW = 3;

  localparam logic signed [LIM_W-1:0] DRIVE_UPPER_RST = 32'sd5898240;
  localparam logic signed [LIM_W-1:0] SAT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [LIM_W-1:0] SAT32_MIN = 32'sh8000_0000;
  localparam logic signed [INT_W-1:0] SAT48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [INT_W-1:0] SAT48_MIN = 48'sh8000_0000_0000;

  typedef enum logic [CFG_IW-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_D      = 3'd1,
    CFG_GAIN_I      = 3'd2,
    CFG_DRIVE_UPPER = 3'd3,
    CFG_DRIVE_LOWER = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INTMUL,
    S_INTACC,
    S_PACC,
    S_IACC,
    S_DWAIT,
    S_DMUL,
    S_DACC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/pcc_div.sv =====
// Restoring divider: 32-bit unsigned dividend by 16-bit divisor, one quotient bit per cycle.
module pcc_div import pcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [QUO_W-1:0]   dividend_i,
  input  logic [TS_W-1:0]    divisor_i,
  output div_stat_t          stat_o,
  output logic [QUO_W-1:0]   quotient_o
);

  logic                     busy_q, done_q;
  logic [$clog2(QUO_W)-1:0] cnt_q;
  logic [QUO_W-1:0]         quo_q;
  logic [TS_W-1:0]          rem_q;
  logic [TS_W-1:0]          dsr_q;
  logic [TS_W:0]            rem_sh;
  logic                     ge;
  logic [TS_W:0]            rem_diff;

  assign rem_sh   = {rem_q, quo_q[QUO_W-1]};
  assign ge       = rem_sh >= {1'b0, dsr_q};
  assign rem_diff = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == {$clog2(QUO_W){1'b1}}) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[QUO_W-2:0], ge};
      rem_q <= ge ? rem_diff[TS_W-1:0] : rem_sh[TS_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== src/pcc_mac.sv =====
// Shared multiply-accumulate unit: registered 17x33 signed product and 50-bit accumulator.
module pcc_mac import pcc_pkg::*; (
  input  logic                     clk_i,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [MUL_AW-1:0] a_i,
  input  logic signed [MUL_BW-1:0] b_i,
  output logic signed [ACC_W-1:0]  prod_o,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [ACC_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= ctrl_i.acc_clr ? prod_q : acc_q + prod_q;
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

// ===== src/pid_controller_clamped.sv =====
// Top level: clamped PID controller, sequencer around a shared MAC unit and a serial divider.
// Steps: integral product, integral update, P and I accumulate, divider wait, D product and sum, output.
// A new item is taken only after the previous result has moved into the output register.
// A finished result waits in the output register while the next item is accepted.
// Reset: gains 0, upper limit 5898240, lower limit 0, deviation history and integral 0.
// No clearing pass; the block is ready right after reset.
module pid_controller_clamped import pcc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IW-1:0]        cfg_idx_i,
  input  logic [LIM_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DEV_W-1:0]  deviation_i,
  input  logic [TS_W-1:0]          time_step_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [LIM_W-1:0]  drive_o,
  output logic                     clamped_o
);

  state_e state_q, state_d;

  logic signed [GAIN_W-1:0] gain_p_q, gain_d_q, gain_i_q;
  logic signed [LIM_W-1:0]  drive_upper_q, drive_lower_q;
  logic signed [DEV_W-1:0]  last_q, dev_q;
  logic [TS_W-1:0]          ts_q;
  logic signed [INT_W-1:0]  integral_q;
  logic                     out_valid_q;
  logic signed [LIM_W-1:0]  drive_q;
  logic                     clamped_q;

  mac_ctrl_t                mac_ctrl;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [ACC_W-1:0]  prod, acc;
  div_stat_t                div_stat;
  logic                     div_start;
  logic [QUO_W-1:0]         quo;

  logic                     in_take, int_we, out_load;

  logic signed [DEV_W:0]    diff;
  logic [DEV_W:0]           mag;
  logic signed [LIM_W-1:0]  deriv;
  logic signed [INT_W:0]    int_sum;
  logic signed [INT_W-1:0]  int_next;
  logic signed [LIM_W-1:0]  sat_drive;
  logic signed [LIM_W-1:0]  fin_drive;
  logic                     fin_clamped;

  pcc_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  pcc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag[DEV_W-1:0], {(QUO_W-DEV_W){1'b0}}}),
    .divisor_i  (ts_q),
    .stat_o     (div_stat),
    .quotient_o (quo)
  );

  assign diff = {dev_q[DEV_W-1], dev_q} - {last_q[DEV_W-1], last_q};
  assign mag  = diff[DEV_W] ? (DEV_W+1)'(-diff) : diff;

  always_comb begin
    if (last_q == '0) begin
      deriv = '0;
    end else if (ts_q == '0) begin
      priority if (diff > 0) begin
        deriv = SAT32_MAX;
      end else if (diff < 0) begin
        deriv = SAT32_MIN;
      end else begin
        deriv = '0;
      end
    end else if (!diff[DEV_W]) begin
      deriv = quo[QUO_W-1] ? SAT32_MAX : $signed(quo);
    end else begin
      deriv = (quo > 32'h8000_0000) ? SAT32_MIN : $signed(QUO_W'(-quo));
    end
  end

  assign int_sum = {integral_q[INT_W-1], integral_q} + prod[INT_W:0];
  always_comb begin
    if (int_sum[INT_W] != int_sum[INT_W-1]) begin
      int_next = int_sum[INT_W] ? SAT48_MIN : SAT48_MAX;
    end else begin
      int_next = int_sum[INT_W-1:0];
    end
  end

  always_comb begin
    priority if (acc > ACC_W'(SAT32_MAX)) begin
      sat_drive = SAT32_MAX;
    end else if (acc < ACC_W'(SAT32_MIN)) begin
      sat_drive = SAT32_MIN;
    end else begin
      sat_drive = acc[LIM_W-1:0];
    end
    fin_clamped = 1'b1;
    priority if (sat_drive > drive_upper_q) begin
      fin_drive = drive_upper_q;
    end else if (sat_drive < drive_lower_q) begin
      fin_drive = drive_lower_q;
    end else begin
      fin_drive   = sat_drive;
      fin_clamped = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    in_take    = 1'b0;
    int_we     = 1'b0;
    out_load   = 1'b0;
    div_start  = 1'b0;
    mac_ctrl   = '0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          in_take = 1'b1;
          state_d = S_INTMUL;
        end
      end
      S_INTMUL: begin
        mul_a           = {last_q[DEV_W-1], last_q} + {dev_q[DEV_W-1], dev_q};
        mul_b           = {{(MUL_BW-TS_W){1'b0}}, ts_q};
        mac_ctrl.mul_en = 1'b1;
        div_start       = 1'b1;
        state_d         = S_INTACC;
      end
      S_INTACC: begin
        int_we          = 1'b1;
        mul_a           = MUL_AW'(gain_p_q);
        mul_b           = MUL_BW'(dev_q);
        mac_ctrl.mul_en = 1'b1;
        state_d         = S_PACC;
      end
      S_PACC: begin
        mac_ctrl.acc_en  = 1'b1;
        mac_ctrl.acc_clr = 1'b1;
        mul_a            = MUL_AW'(gain_i_q);
        mul_b            = MUL_BW'($signed(integral_q[INT_W-1:INT_W-LIM_W]));
        mac_ctrl.mul_en  = 1'b1;
        state_d          = S_IACC;
      end
      S_IACC: begin
        mac_ctrl.acc_en = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_stat.done) begin
          state_d = S_DMUL;
        end
      end
      S_DMUL: begin
        mul_a           = MUL_AW'(gain_d_q);
        mul_b           = MUL_BW'(deriv);
        mac_ctrl.mul_en = 1'b1;
        state_d         = S_DACC;
      end
      S_DACC: begin
        mac_ctrl.acc_en = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q      <= '0;
      gain_d_q      <= '0;
      gain_i_q      <= '0;
      drive_upper_q <= DRIVE_UPPER_RST;
      drive_lower_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN_P:      gain_p_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D:      gain_d_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I:      gain_i_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_DRIVE_UPPER: drive_upper_q <= cfg_data_i;
        CFG_DRIVE_LOWER: drive_lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      integral_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (int_we) begin
        integral_q <= int_next;
      end
      if (out_load) begin
        last_q      <= dev_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      dev_q <= deviation_i;
      ts_q  <= time_step_i;
    end
    if (out_load) begin
      drive_q   <= fin_drive;
      clamped_q <= fin_clamped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign clamped_o   = clamped_q;

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted on the cycle after a transfer");

  a_div_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q != S_IDLE))
    else $error("divider running while sequencer is idle");

  a_dmul_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DMUL) |-> (div_stat.done && !div_stat.busy))
    else $error("derivative used before division finished");

  a_out_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not loaded into free output register");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the clamped PID controller: directed table plus random traffic, self-checked.
`timescale 1ns / 100ps

module tb_top;
  import pcc_pkg::*;

  localparam int NUM_DIR      = 38;
  localparam int SEG_ITEMS    = 167;
  localparam int SEGS         = 4;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic signed [LIM_W-1:0] drive;
    logic                    clamped;
  } drive_res_t;

  typedef enum logic [1:0] {DIR_WRITE, DIR_ITEM, DIR_KNOWN} dir_kind_e;

  typedef struct packed {
    dir_kind_e               kind;
    logic [CFG_IW-1:0]       idx;
    logic [LIM_W-1:0]        val;
    logic signed [DEV_W-1:0] dev;
    logic [TS_W-1:0]         ts;
    logic signed [LIM_W-1:0] drive;
    logic                    clamped;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IW-1:0]       cfg_idx_i = '0;
  logic [LIM_W-1:0]        cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [DEV_W-1:0] deviation_i = '0;
  logic [TS_W-1:0]         time_step_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [LIM_W-1:0] drive_o;
  logic                    clamped_o;

  longint                  kp, kd, ki, lim_hi, lim_lo;
  logic signed [DEV_W-1:0] hist_dev;
  logic signed [INT_W-1:0] integ_acc;

  drive_res_t              drive_q[$];
  drive_res_t              want;
  bit                      pin_known = 1'b0;
  logic signed [LIM_W-1:0] pin_drive = '0;
  logic                    pin_clamped = 1'b0;
  int                      snd_idle_pct = 8;
  int                      rcv_idle_pct = 68;
  int                      err_cnt = 0;
  int                      stall_cycles = 0;
  bit                      moved;
  dir_row_t                dir_tbl [NUM_DIR];

  pid_controller_clamped i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .deviation_i (deviation_i),
    .time_step_i (time_step_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o),
    .clamped_o   (clamped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat_to(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic drive_res_t predict_drive(logic signed [DEV_W-1:0] dev,
                                               logic [TS_W-1:0] ts);
    longint     cur, prev, span, acc, rate, total;
    drive_res_t res;
    cur  = longint'(dev);
    prev = longint'(hist_dev);
    span = longint'(ts);
    acc  = sat_to(integ_acc + (prev + cur) * span, longint'(SAT48_MIN), longint'(SAT48_MAX));
    integ_acc = INT_W'(acc);
    rate = 0;
    if (prev != 0) begin
      if (span == 0) begin
        if (cur > prev) rate = longint'(SAT32_MAX);
        else if (cur < prev) rate = longint'(SAT32_MIN);
      end else begin
        rate = sat_to(((cur - prev) * 65536) / span, longint'(SAT32_MIN), longint'(SAT32_MAX));
      end
    end
    total = sat_to(kp * cur + kd * rate + ki * (acc >>> 16),
                   longint'(SAT32_MIN), longint'(SAT32_MAX));
    res.clamped = 1'b0;
    if (total > lim_hi) begin
      total = lim_hi;
      res.clamped = 1'b1;
    end else if (total < lim_lo) begin
      total = lim_lo;
      res.clamped = 1'b1;
    end
    res.drive = LIM_W'(total);
    hist_dev = dev;
    return res;
  endfunction

  function automatic void apply_reg(logic [CFG_IW-1:0] idx, logic [LIM_W-1:0] val);
    case (idx)
      CFG_GAIN_P:      kp = longint'($signed(val[GAIN_W-1:0]));
      CFG_GAIN_D:      kd = longint'($signed(val[GAIN_W-1:0]));
      CFG_GAIN_I:      ki = longint'($signed(val[GAIN_W-1:0]));
      CFG_DRIVE_UPPER: lim_hi = longint'($signed(val));
      CFG_DRIVE_LOWER: lim_lo = longint'($signed(val));
      default: ;
    endcase
  endfunction

  function automatic dir_row_t dir_wr(logic [CFG_IW-1:0] idx, logic [LIM_W-1:0] val);
    dir_row_t r;
    r = '0;
    r.kind = DIR_WRITE;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic dir_row_t dir_item(logic signed [DEV_W-1:0] dev, logic [TS_W-1:0] ts);
    dir_row_t r;
    r = '0;
    r.kind = DIR_ITEM;
    r.dev  = dev;
    r.ts   = ts;
    return r;
  endfunction

  function automatic dir_row_t dir_known(logic signed [DEV_W-1:0] dev, logic [TS_W-1:0] ts,
                                         logic signed [LIM_W-1:0] drive, logic clamped);
    dir_row_t r;
    r = dir_item(dev, ts);
    r.kind    = DIR_KNOWN;
    r.drive   = drive;
    r.clamped = clamped;
    return r;
  endfunction

  function automatic logic [LIM_W-1:0] rand_gain();
    logic [LIM_W-1:0] r;
    r = $urandom();
    case ($urandom_range(3))
      0: ;
      1: r[GAIN_W-1:0] = $urandom_range(16) - 8;
      2: r[GAIN_W-1:0] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: r[GAIN_W-1:0] = '0;
    endcase
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [LIM_W-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (drive_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_item(logic signed [DEV_W-1:0] dev, logic [TS_W-1:0] ts, bit known,
                           logic signed [LIM_W-1:0] drv, logic clp);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    deviation_i = dev;
    time_step_i = ts;
    pin_known   = known;
    pin_drive   = drv;
    pin_clamped = clp;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want = predict_drive(deviation_i, time_step_i);
        if (pin_known) begin
          want.drive   = pin_drive;
          want.clamped = pin_clamped;
        end
        drive_q.push_back(want);
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (drive_q.size() == 0) begin
          $error("drive: no result expected, got %0d", drive_o);
          err_cnt++;
        end else begin
          want = drive_q.pop_front();
          if (drive_o !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, drive_o);
            err_cnt++;
          end
          if (clamped_o !== want.clamped) begin
            $error("clamped: expected %0b, got %0b", want.clamped, clamped_o);
            err_cnt++;
          end
        end
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(negedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic signed [DEV_W-1:0] dv;
    logic [TS_W-1:0]         tv;
    logic signed [LIM_W-1:0] la, lb, hi, lo;
    logic [CFG_IW-1:0]       spare;

    kp = 0;
    kd = 0;
    ki = 0;
    lim_hi = DRIVE_UPPER_RST;
    lim_lo = 0;
    hist_dev = '0;
    integ_acc = '0;
    dv = '0;
    dir_tbl = '{
      dir_known(0, 1, 0, 1'b0),
      dir_known(-32768, 65535, 0, 1'b0),
      dir_known(32767, 0, 0, 1'b0),
      dir_wr(CFG_GAIN_P, 32767),
      dir_wr(CFG_DRIVE_UPPER, SAT32_MAX),
      dir_wr(CFG_DRIVE_LOWER, SAT32_MIN),
      dir_known(32767, 1, 1073676289, 1'b0),
      dir_known(-32768, 1, -1073709056, 1'b0),
      dir_wr(CFG_GAIN_D, 32767),
      dir_known(32767, 0, SAT32_MAX, 1'b0),
      dir_known(-32768, 0, SAT32_MIN, 1'b0),
      dir_known(-32768, 0, -1073709056, 1'b0),
      dir_item(0, 65535),
      dir_item(100, 1),
      dir_wr(CFG_GAIN_P, -32768),
      dir_wr(CFG_GAIN_D, -32768),
      dir_wr(CFG_GAIN_I, -32768),
      dir_item(-32768, 65535),
      dir_item(32767, 65535),
      dir_item(-5, 3),
      dir_wr(CFG_DRIVE_LOWER + 3'd1, 1),
      dir_wr(CFG_DRIVE_LOWER + 3'd2, 1),
      dir_wr(CFG_DRIVE_LOWER + 3'd3, 1),
      dir_item(-77, 300),
      dir_wr(CFG_GAIN_P, 1),
      dir_wr(CFG_GAIN_D, 0),
      dir_wr(CFG_GAIN_I, 0),
      dir_wr(CFG_DRIVE_UPPER, 100),
      dir_wr(CFG_DRIVE_LOWER, -100),
      dir_known(101, 1, 100, 1'b1),
      dir_known(-101, 1, -100, 1'b1),
      dir_known(100, 1, 100, 1'b0),
      dir_known(-100, 1, -100, 1'b0),
      dir_wr(CFG_DRIVE_UPPER, -1000),
      dir_wr(CFG_DRIVE_LOWER, 1000),
      dir_known(0, 1, -1000, 1'b1),
      dir_known(-1000, 1, 1000, 1'b1),
      dir_known(-32768, 1, 1000, 1'b1)
    };

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == DIR_WRITE) begin
        wait_drained();
        write_reg(dir_tbl[i].idx, dir_tbl[i].val);
      end else begin
        send_item(dir_tbl[i].dev, dir_tbl[i].ts, dir_tbl[i].kind == DIR_KNOWN,
                  dir_tbl[i].drive, dir_tbl[i].clamped);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      snd_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 68 : 0;
      rcv_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 8 : 0;
      for (int seg = 0; seg < SEGS; seg++) begin
        wait_drained();
        write_reg(CFG_GAIN_P, rand_gain());
        write_reg(CFG_GAIN_D, rand_gain());
        write_reg(CFG_GAIN_I, rand_gain());
        case ($urandom_range(4))
          0: begin
            hi = SAT32_MAX;
            lo = SAT32_MIN;
          end
          1: begin
            hi = DRIVE_UPPER_RST;
            lo = '0;
          end
          2: begin
            la = $urandom();
            lb = $urandom();
            hi = (la > lb) ? la : lb;
            lo = (la > lb) ? lb : la;
          end
          3: begin
            hi = $urandom_range(1 << 24);
            lo = -int'($urandom_range(1 << 24));
          end
          default: begin
            hi = $urandom();
            lo = $urandom();
          end
        endcase
        write_reg(CFG_DRIVE_UPPER, hi);
        write_reg(CFG_DRIVE_LOWER, lo);
        if ($urandom_range(1)) begin
          spare = CFG_DRIVE_LOWER + $urandom_range(3, 1);
          write_reg(spare, $urandom());
        end
        for (int n = 0; n < SEG_ITEMS; n++) begin
          case ($urandom_range(9))
            0: dv = '0;
            1: dv = 16'sh7FFF;
            2: dv = 16'sh8000;
            3: dv = $urandom_range(128) - 64;
            4: ;
            default: dv = $urandom();
          endcase
          case ($urandom_range(9))
            0: tv = '0;
            1: tv = 1;
            2: tv = '1;
            3: tv = $urandom_range(16, 1);
            default: tv = $urandom();
          endcase
          send_item(dv, tv, 1'b0, '0, 1'b0);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
